// File: rtl/lmtq_pkg.sv
// shared types and constants for the linear move tween queue
package lmtq_pkg;

  localparam int unsigned AXES = 3;

  localparam logic [0:0] CMD_TICK = 1'b0;
  localparam logic [0:0] CMD_ADD  = 1'b1;

  localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [AXES-1:0][31:0] goal;
    logic [AXES-1:0][31:0] step;
    logic [16:0]           timer;
    logic [15:0]           delay;
    logic [15:0]           length;
    logic                  offset_mode;
  } slot_rec_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_LOAD = 7'b0000100,
    ST_AXIS = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_ADD  = 7'b0100000,
    ST_WB   = 7'b1000000
  } state_t;

endpackage

// File: rtl/linear_move_tween_queue_top.sv
// linear move tween queue top level with slot memory and serial divider
// An add transaction queues a 3D move if a slot is free; its result is then
// loaded into the output register once the output is free. A tick walks the
// queued moves oldest first. A move still waiting out its delay passes through
// read, load, check and write back. An active move passes through read, load
// and write back, plus a check and an add per axis. On its first active tick it
// also passes through a divide per axis, where one shared restoring divider
// works out its step one quotient bit a cycle.
// Input stall stays high while a transaction is being worked on and while its
// result waits for a stalled output.
module linear_move_tween_queue_top
  import lmtq_pkg::*;
#(
  parameter int unsigned MOVE_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_goal_x,
  input  logic [31:0] in_goal_y,
  input  logic [31:0] in_goal_z,
  input  logic [15:0] in_duration,
  input  logic [15:0] in_start_delay,
  input  logic        in_relative,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_new_x,
  output logic [31:0] out_new_y,
  output logic [31:0] out_new_z,
  output logic        out_accepted,
  output logic [3:0]  out_active_moves
);

  localparam int unsigned CW = $clog2(MOVE_SLOTS + 1);
  localparam int unsigned IW = (MOVE_SLOTS > 1) ? $clog2(MOVE_SLOTS) : 1;

  state_t state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] s_r;
  logic [CW-1:0] keep_r;
  logic [1:0] axis_r;
  logic [AXES-1:0][31:0] pos_r;
  slot_rec_t cur_r;
  slot_rec_t rd_r;
  logic active_r;
  logic first_r;
  logic accepted_r;
  logic pending_r;
  logic [32:0] quo_r;
  logic [15:0] rem_r;
  logic [5:0] div_cnt_r;
  logic neg_r;

  logic out_valid_r;
  logic [AXES-1:0][31:0] out_pos_r;
  logic out_accepted_r;
  logic [3:0] out_moves_r;

  slot_rec_t mem [MOVE_SLOTS];
  logic wr_en;
  logic [IW-1:0] wr_addr;
  slot_rec_t wr_data;

  logic accept;
  logic out_free;
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic [16:0] rem_sh;
  logic rem_ge;
  logic [31:0] q_sat;
  logic signed [32:0] pos_sum;
  logic [31:0] pos_sat;
  logic [16:0] timer_n;
  logic keep_slot;
  slot_rec_t add_rec;

  assign in_stall = (state_r != ST_IDLE) || pending_r;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    diff = $signed({cur_r.goal[axis_r][31], cur_r.goal[axis_r]});
    if (!cur_r.offset_mode) begin
      diff = diff - $signed({pos_r[axis_r][31], pos_r[axis_r]});
    end
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  assign rem_sh = {rem_r, quo_r[32]};
  assign rem_ge = rem_sh >= {1'b0, cur_r.length};

  always_comb begin
    if (!neg_r) begin
      q_sat = (quo_r[32:31] != 2'b00) ? POS_MAX : quo_r[31:0];
    end else if (quo_r > 33'h0_8000_0000) begin
      q_sat = POS_MIN;
    end else begin
      q_sat = 32'(-quo_r);
    end
  end

  always_comb begin
    pos_sum = $signed({pos_r[axis_r][31], pos_r[axis_r]})
            + $signed({cur_r.step[axis_r][31], cur_r.step[axis_r]});
    if (pos_sum > $signed({POS_MAX[31], POS_MAX})) begin
      pos_sat = POS_MAX;
    end else if (pos_sum < $signed({POS_MIN[31], POS_MIN})) begin
      pos_sat = POS_MIN;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  assign timer_n   = cur_r.timer + 17'd1;
  assign keep_slot = timer_n < ({1'b0, cur_r.length} + {1'b0, cur_r.delay});

  always_comb begin
    add_rec.goal        = {in_goal_z, in_goal_y, in_goal_x};
    add_rec.step        = '0;
    add_rec.timer       = '0;
    add_rec.delay       = in_start_delay;
    add_rec.length      = (in_duration == 16'd0) ? 16'd1 : in_duration;
    add_rec.offset_mode = in_relative;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = keep_r[IW-1:0];
    wr_data = cur_r;
    wr_data.timer = timer_n;
    if (state_r == ST_IDLE) begin
      wr_en   = accept && (in_command == CMD_ADD) && (count_r < CW'(MOVE_SLOTS));
      wr_addr = count_r[IW-1:0];
      wr_data = add_rec;
    end else if (state_r == ST_WB) begin
      wr_en = keep_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[s_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      s_r         <= '0;
      keep_r      <= '0;
      axis_r      <= '0;
      div_cnt_r   <= '0;
    end else begin
      if (pending_r && out_free) begin
        out_valid_r    <= 1'b1;
        out_pos_r      <= pos_r;
        out_accepted_r <= accepted_r;
        out_moves_r    <= 4'(count_r);
        pending_r      <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            pos_r      <= {in_pos_z, in_pos_y, in_pos_x};
            s_r        <= '0;
            keep_r     <= '0;
            accepted_r <= 1'b0;
            if (in_command == CMD_ADD) begin
              pending_r <= 1'b1;
              if (count_r < CW'(MOVE_SLOTS)) begin
                count_r    <= count_r + CW'(1);
                accepted_r <= 1'b1;
              end
            end else if (count_r == '0) begin
              pending_r <= 1'b1;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          cur_r    <= rd_r;
          active_r <= rd_r.timer >= {1'b0, rd_r.delay};
          first_r  <= rd_r.timer == {1'b0, rd_r.delay};
          axis_r   <= '0;
          state_r  <= ST_AXIS;
        end
        ST_AXIS: begin
          if (!active_r) begin
            state_r <= ST_WB;
          end else if (first_r) begin
            quo_r     <= diff_mag;
            neg_r     <= diff[32];
            rem_r     <= '0;
            div_cnt_r <= 6'd33;
            state_r   <= ST_DIV;
          end else begin
            state_r <= ST_ADD;
          end
        end
        ST_DIV: begin
          if (div_cnt_r == '0) begin
            cur_r.step[axis_r] <= q_sat;
            state_r <= ST_ADD;
          end else begin
            rem_r     <= rem_ge ? 16'(rem_sh - {1'b0, cur_r.length}) : rem_sh[15:0];
            quo_r     <= {quo_r[31:0], rem_ge};
            div_cnt_r <= div_cnt_r - 6'd1;
          end
        end
        ST_ADD: begin
          pos_r[axis_r] <= pos_sat;
          if (axis_r == 2'd2) begin
            state_r <= ST_WB;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= ST_AXIS;
          end
        end
        ST_WB: begin
          s_r <= s_r + CW'(1);
          if (keep_slot) begin
            keep_r <= keep_r + CW'(1);
          end
          if (s_r + CW'(1) == count_r) begin
            count_r   <= keep_slot ? keep_r + CW'(1) : keep_r;
            pending_r <= 1'b1;
            state_r   <= ST_IDLE;
          end else begin
            state_r <= ST_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_x        = out_pos_r[0];
  assign out_new_y        = out_pos_r[1];
  assign out_new_z        = out_pos_r[2];
  assign out_accepted     = out_accepted_r;
  assign out_active_moves = out_moves_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MOVE_SLOTS))
    else $error("queue count beyond slot count");

  a_keep_le_scan: assert property (@(posedge clk) disable iff (!rst_n)
    keep_r <= s_r)
    else $error("compaction index ahead of scan index");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (s_r < count_r))
    else $error("slot read beyond queue");

  a_div_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cur_r.length != 16'd0))
    else $error("divide by zero length");
`endif

endmodule
